// ----- rtl/assert_macros.svh -----
// assertion macros used by the checker file
// depends on a clk and an active-low rst_n in the including scope
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked check, off while reset is held
`define HCL_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// clocked check that also runs across reset
`define HCL_ASSERT_RST(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- rtl/hcl_pkg.sv -----
// package for the huffman code length builder
// types, operation codes and the bit reverse helper; no dependencies
`default_nettype none

package hcl_pkg;

  localparam int SYM_BITS   = 9;
  localparam int CNT_BITS   = 25;
  localparam int LEN_BITS   = 9;
  localparam int CODE_BITS  = 15;
  localparam int NCODE_BITS = 16;

  localparam logic [1:0] OP_LOAD  = 2'd0;
  localparam logic [1:0] OP_BUILD = 2'd1;
  localparam logic [1:0] OP_READ  = 2'd2;

  localparam logic KIND_STATUS = 1'b0;
  localparam logic KIND_ENTRY  = 1'b1;

  localparam logic REG_SYMBOLS   = 1'b0;
  localparam logic REG_INCREMENT = 1'b1;

  typedef struct packed {
    logic [1:0]          operation;
    logic [SYM_BITS-1:0] symbol_index;
    logic [15:0]         symbol_count;
  } in_word_t;

  typedef struct packed {
    logic                 result_kind;
    logic [3:0]           code_length;
    logic [CODE_BITS-1:0] code_bits;
    logic                 length_overflow;
  } out_word_t;

  // two smallest nonzero counts seen in a scan
  typedef struct packed {
    logic                have1;
    logic                have2;
    logic [CNT_BITS-1:0] c1;
    logic [CNT_BITS-1:0] c2;
    logic [SYM_BITS-1:0] i1;
    logic [SYM_BITS-1:0] i2;
  } pick_t;

  // reverse the low len bits of v
  function automatic logic [CODE_BITS-1:0] rev_code(input logic [CODE_BITS-1:0] v,
                                                    input logic [3:0] len);
    logic [CODE_BITS-1:0] r;
    for (int b = 0; b < CODE_BITS; b++) begin
      r[b] = v[CODE_BITS-1-b];
    end
    rev_code = r >> (4'(CODE_BITS) - len);
  endfunction

endpackage

`default_nettype wire

// ----- rtl/hcl_ram.sv -----
// generic simple dual port ram, one write and one registered read port
// no dependencies
`default_nettype none

module hcl_ram #(
  parameter int W = 8,
  parameter int D = 16
) (
  input  wire logic                 clk,
  input  wire logic                 we,
  input  wire logic [$clog2(D)-1:0] waddr,
  input  wire logic [W-1:0]         wdata,
  input  wire logic [$clog2(D)-1:0] raddr,
  output logic      [W-1:0]         rdata
);

  logic [W-1:0] mem [D];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ----- rtl/hcl_min2.sv -----
// compare unit tracking the two smallest nonzero counts of a scan
// depends on hcl_pkg
`default_nettype none

module hcl_min2 (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         clr,
  input  wire logic                         en,
  input  wire logic [hcl_pkg::CNT_BITS-1:0] cnt,
  input  wire logic [hcl_pkg::SYM_BITS-1:0] idx,
  output hcl_pkg::pick_t                    pick
);

  hcl_pkg::pick_t pick_r, pick_nxt;

  // ties keep the earlier (lower) index
  always_comb begin
    pick_nxt = pick_r;
    if (clr) begin
      pick_nxt.have1 = 1'b0;
      pick_nxt.have2 = 1'b0;
    end else if (en && cnt != '0) begin
      if (!pick_r.have1 || cnt < pick_r.c1) begin
        if (pick_r.have1) begin
          pick_nxt.c2    = pick_r.c1;
          pick_nxt.i2    = pick_r.i1;
          pick_nxt.have2 = 1'b1;
        end
        pick_nxt.c1    = cnt;
        pick_nxt.i1    = idx;
        pick_nxt.have1 = 1'b1;
      end else if (!pick_r.have2 || cnt < pick_r.c2) begin
        pick_nxt.c2    = cnt;
        pick_nxt.i2    = idx;
        pick_nxt.have2 = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pick_r.have1 <= 1'b0;
      pick_r.have2 <= 1'b0;
    end else begin
      pick_r.have1 <= pick_nxt.have1;
      pick_r.have2 <= pick_nxt.have2;
    end
    pick_r.c1 <= pick_nxt.c1;
    pick_r.c2 <= pick_nxt.c2;
    pick_r.i1 <= pick_nxt.i1;
    pick_r.i2 <= pick_nxt.i2;
  end

  assign pick = pick_r;

endmodule

`default_nettype wire

// ----- rtl/huffman_code_length_builder.sv -----
// huffman code length builder: loads counts, builds canonical deflate codes
// depends on hcl_pkg, hcl_ram and hcl_min2
//
//  channel | direction | handshake        | word
//  in_     | input     | in_valid/stall   | hcl_pkg::in_word_t
//  out_    | output    | out_valid/stall  | hcl_pkg::out_word_t
//  cfg_    | input     | cfg_valid/ready  | cfg_index, cfg_data
//
// a load is written in idle; a read passes through S_RD1 and S_RD2 and the
// registered ram read; build: an init sweep over MAX_SYMBOLS, then per merge
// round a scan, three merge setup steps and a group sweep, then a last scan,
// the length check, the next code table and the code sweep;
// in_stall is high for the whole of a read or build
// synchronous reset, rams not cleared at reset; reads give zero before a build
`default_nettype none

module huffman_code_length_builder #(
  parameter int MAX_SYMBOLS  = 286,
  parameter int MAX_CODE_LEN = 15
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output logic                     in_stall,
  input  wire hcl_pkg::in_word_t   in_word,
  output logic                     out_valid,
  input  wire logic                out_stall,
  output hcl_pkg::out_word_t       out_word,
  input  wire logic                cfg_valid,
  output logic                     cfg_ready,
  input  wire logic                cfg_index,
  input  wire logic [8:0]          cfg_data
);

  localparam int AW    = $clog2(MAX_SYMBOLS);
  localparam int CW    = $clog2(MAX_SYMBOLS + 1);
  localparam int LW    = $clog2(MAX_CODE_LEN + 1);
  localparam int TD    = MAX_CODE_LEN + 1;
  localparam int CNTB  = hcl_pkg::CNT_BITS;
  localparam int LENB  = hcl_pkg::LEN_BITS;
  localparam int CODEB = hcl_pkg::CODE_BITS;
  localparam int NXB   = hcl_pkg::NCODE_BITS;

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_RD1   = 4'd1;
  localparam logic [3:0] S_RD2   = 4'd2;
  localparam logic [3:0] S_INIT  = 4'd3;
  localparam logic [3:0] S_SCAN  = 4'd4;
  localparam logic [3:0] S_MW1   = 4'd5;
  localparam logic [3:0] S_MW2   = 4'd6;
  localparam logic [3:0] S_MG2   = 4'd7;
  localparam logic [3:0] S_MRG   = 4'd8;
  localparam logic [3:0] S_LONER = 4'd9;
  localparam logic [3:0] S_LONEW = 4'd10;
  localparam logic [3:0] S_CHK   = 4'd11;
  localparam logic [3:0] S_NC    = 4'd12;
  localparam logic [3:0] S_CODE  = 4'd13;
  localparam logic [3:0] S_DONE  = 4'd14;

  logic [3:0]    state_r, state_nxt;
  logic [CW-1:0] sw_cnt_r, sw_cnt_nxt;
  logic          pend_r, pend_nxt;
  logic [AW-1:0] pend_idx_r, pend_idx_nxt;
  logic [CW-1:0] n_r, n_nxt;
  logic [AW-1:0] idx_r, idx_nxt;
  logic          idx_ok_r, idx_ok_nxt;
  logic          built_r, built_nxt;
  logic [AW-1:0] g1_r, g1_nxt;
  logic [AW-1:0] g2_r, g2_nxt;
  logic          over_r, over_nxt;
  logic [LW-1:0] k_r, k_nxt;
  logic [CW-1:0] hist_r [TD];
  logic [CW-1:0] hist_nxt [TD];
  logic [NXB-1:0] nc_r [TD];
  logic [NXB-1:0] nc_nxt [TD];
  logic          out_valid_r, out_valid_nxt;
  hcl_pkg::out_word_t out_word_r, out_word_nxt;
  logic [8:0]    sym_r, sym_nxt;
  logic [7:0]    inc_r, inc_nxt;

  // ram ports
  logic            cnt_we, len_we, grp_we, code_we;
  logic [AW-1:0]   cnt_waddr, len_waddr, grp_waddr, code_waddr;
  logic [AW-1:0]   cnt_raddr, len_raddr, grp_raddr, code_raddr;
  logic [CNTB-1:0] cnt_wdata, cnt_rdata;
  logic [LENB-1:0] len_wdata, len_rdata;
  logic [AW-1:0]   grp_wdata, grp_rdata;
  logic [CODEB-1:0] code_wdata, code_rdata;

  // compare unit
  logic           mn_clr, mn_en;
  hcl_pkg::pick_t pick;

  logic          issue, out_free, in_ok, go_chk;
  logic [9:0]    n_cap;
  logic [AW-1:0] sw_addr;
  logic [LW-1:0] len_idx;
  logic [LENB-1:0] rd_len;

  hcl_ram #(.W(CNTB), .D(MAX_SYMBOLS)) u_cnt_ram (
    .clk(clk), .we(cnt_we), .waddr(cnt_waddr), .wdata(cnt_wdata),
    .raddr(cnt_raddr), .rdata(cnt_rdata)
  );
  hcl_ram #(.W(LENB), .D(MAX_SYMBOLS)) u_len_ram (
    .clk(clk), .we(len_we), .waddr(len_waddr), .wdata(len_wdata),
    .raddr(len_raddr), .rdata(len_rdata)
  );
  hcl_ram #(.W(AW), .D(MAX_SYMBOLS)) u_grp_ram (
    .clk(clk), .we(grp_we), .waddr(grp_waddr), .wdata(grp_wdata),
    .raddr(grp_raddr), .rdata(grp_rdata)
  );
  hcl_ram #(.W(CODEB), .D(MAX_SYMBOLS)) u_code_ram (
    .clk(clk), .we(code_we), .waddr(code_waddr), .wdata(code_wdata),
    .raddr(code_raddr), .rdata(code_rdata)
  );

  hcl_min2 u_min2 (
    .clk(clk), .rst_n(rst_n), .clr(mn_clr), .en(mn_en),
    .cnt(cnt_rdata), .idx(hcl_pkg::SYM_BITS'(pend_idx_r)), .pick(pick)
  );

  assign in_stall  = (state_r != S_IDLE);
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

  assign issue    = (sw_cnt_r < n_r);
  assign out_free = !out_valid_r || !out_stall;
  assign in_ok    = (10'(in_word.symbol_index) < 10'(MAX_SYMBOLS));
  assign n_cap    = (10'(sym_r) > 10'(MAX_SYMBOLS)) ? 10'(MAX_SYMBOLS) : 10'(sym_r);
  assign sw_addr  = sw_cnt_r[AW-1:0];
  assign len_idx  = len_rdata[LW-1:0];
  assign rd_len   = (built_r && idx_ok_r) ? len_rdata : '0;

  // sequencer
  always_comb begin
    state_nxt     = state_r;
    sw_cnt_nxt    = sw_cnt_r;
    pend_nxt      = 1'b0;
    pend_idx_nxt  = pend_idx_r;
    n_nxt         = n_r;
    idx_nxt       = idx_r;
    idx_ok_nxt    = idx_ok_r;
    built_nxt     = built_r;
    g1_nxt        = g1_r;
    g2_nxt        = g2_r;
    over_nxt      = over_r;
    k_nxt         = k_r;
    hist_nxt      = hist_r;
    nc_nxt        = nc_r;
    out_valid_nxt = out_valid_r;
    out_word_nxt  = out_word_r;
    sym_nxt       = sym_r;
    inc_nxt       = inc_r;
    cnt_we = 1'b0; len_we = 1'b0; grp_we = 1'b0; code_we = 1'b0;
    cnt_waddr = sw_addr; len_waddr = sw_addr; grp_waddr = sw_addr; code_waddr = sw_addr;
    cnt_raddr = sw_addr; len_raddr = sw_addr; grp_raddr = sw_addr; code_raddr = sw_addr;
    cnt_wdata  = '0;
    len_wdata  = '0;
    grp_wdata  = sw_addr;
    code_wdata = '0;
    mn_clr = 1'b0;
    mn_en  = 1'b0;
    go_chk = 1'b0;

    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    // configuration writes
    if (cfg_valid) begin
      case (cfg_index)
        hcl_pkg::REG_SYMBOLS:   sym_nxt = cfg_data;
        hcl_pkg::REG_INCREMENT: inc_nxt = cfg_data[7:0];
        default: ;
      endcase
    end

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          case (in_word.operation)
            hcl_pkg::OP_LOAD: begin
              cnt_we    = in_ok;
              cnt_waddr = in_word.symbol_index[AW-1:0];
              cnt_wdata = CNTB'(in_word.symbol_count);
            end
            hcl_pkg::OP_BUILD: begin
              n_nxt      = CW'(n_cap);
              sw_cnt_nxt = '0;
              built_nxt  = 1'b1;
              state_nxt  = S_INIT;
            end
            hcl_pkg::OP_READ: begin
              idx_nxt    = in_word.symbol_index[AW-1:0];
              idx_ok_nxt = in_ok;
              state_nxt  = S_RD1;
            end
            default: ;
          endcase
        end
      end
      S_RD1: begin
        len_raddr  = idx_r;
        code_raddr = idx_r;
        state_nxt  = S_RD2;
      end
      S_RD2: begin
        len_raddr  = idx_r;
        code_raddr = idx_r;
        if (out_free) begin
          out_valid_nxt                = 1'b1;
          out_word_nxt.result_kind     = hcl_pkg::KIND_ENTRY;
          out_word_nxt.code_length     = (rd_len > LENB'(15)) ? 4'd15 : rd_len[3:0];
          out_word_nxt.code_bits       = (built_r && idx_ok_r) ? code_rdata : '0;
          out_word_nxt.length_overflow = 1'b0;
          state_nxt                    = S_IDLE;
        end else begin
          state_nxt = S_RD1;
        end
      end
      // clear lengths and codes, each symbol its own group
      S_INIT: begin
        len_we  = 1'b1;
        grp_we  = 1'b1;
        code_we = 1'b1;
        if (sw_cnt_r == CW'(MAX_SYMBOLS - 1)) begin
          sw_cnt_nxt = '0;
          mn_clr     = 1'b1;
          state_nxt  = S_SCAN;
        end else begin
          sw_cnt_nxt = sw_cnt_r + 1'b1;
        end
      end
      // find the two smallest nonzero counts
      S_SCAN: begin
        if (issue) begin
          pend_nxt     = 1'b1;
          pend_idx_nxt = sw_addr;
          sw_cnt_nxt   = sw_cnt_r + 1'b1;
        end
        if (pend_r) begin
          mn_en = 1'b1;
        end
        if (!issue && !pend_r) begin
          if (pick.have2) begin
            state_nxt = S_MW1;
          end else if (pick.have1) begin
            state_nxt = S_LONER;
          end else begin
            go_chk = 1'b1;
          end
        end
      end
      S_MW1: begin
        cnt_we    = 1'b1;
        cnt_waddr = pick.i1[AW-1:0];
        cnt_wdata = pick.c1 + CNTB'(inc_r) + pick.c2;
        grp_raddr = pick.i1[AW-1:0];
        state_nxt = S_MW2;
      end
      S_MW2: begin
        cnt_we    = 1'b1;
        cnt_waddr = pick.i2[AW-1:0];
        cnt_wdata = '0;
        g1_nxt    = grp_rdata;
        grp_raddr = pick.i2[AW-1:0];
        state_nxt = S_MG2;
      end
      S_MG2: begin
        g2_nxt     = grp_rdata;
        sw_cnt_nxt = '0;
        state_nxt  = S_MRG;
      end
      // members of both groups gain a bit and join the first group
      S_MRG: begin
        if (issue) begin
          pend_nxt     = 1'b1;
          pend_idx_nxt = sw_addr;
          sw_cnt_nxt   = sw_cnt_r + 1'b1;
        end
        if (pend_r && (grp_rdata == g1_r || grp_rdata == g2_r)) begin
          len_we    = 1'b1;
          len_waddr = pend_idx_r;
          len_wdata = len_rdata + 1'b1;
          grp_we    = 1'b1;
          grp_waddr = pend_idx_r;
          grp_wdata = g1_r;
        end
        if (!issue && !pend_r) begin
          sw_cnt_nxt = '0;
          mn_clr     = 1'b1;
          state_nxt  = S_SCAN;
        end
      end
      S_LONER: begin
        len_raddr = pick.i1[AW-1:0];
        state_nxt = S_LONEW;
      end
      S_LONEW: begin
        len_we    = (len_rdata == '0);
        len_waddr = pick.i1[AW-1:0];
        len_wdata = LENB'(1);
        go_chk    = 1'b1;
      end
      // overflow check and length histogram
      S_CHK: begin
        if (issue) begin
          pend_nxt     = 1'b1;
          pend_idx_nxt = sw_addr;
          sw_cnt_nxt   = sw_cnt_r + 1'b1;
        end
        if (pend_r) begin
          if (len_rdata > LENB'(MAX_CODE_LEN)) begin
            over_nxt = 1'b1;
          end else begin
            hist_nxt[len_idx] = hist_r[len_idx] + 1'b1;
          end
        end
        if (!issue && !pend_r) begin
          sw_cnt_nxt = '0;
          k_nxt      = LW'(2);
          if (over_r) begin
            state_nxt = S_DONE;
          end else if (MAX_CODE_LEN < 2) begin
            state_nxt = S_CODE;
          end else begin
            state_nxt = S_NC;
          end
        end
      end
      // first code of each length
      S_NC: begin
        nc_nxt[k_r] = (nc_r[k_r - 1'b1] + NXB'(hist_r[k_r - 1'b1])) << 1;
        if (k_r == LW'(MAX_CODE_LEN)) begin
          sw_cnt_nxt = '0;
          state_nxt  = S_CODE;
        end else begin
          k_nxt = k_r + 1'b1;
        end
      end
      // assign codes in symbol order
      S_CODE: begin
        if (issue) begin
          pend_nxt     = 1'b1;
          pend_idx_nxt = sw_addr;
          sw_cnt_nxt   = sw_cnt_r + 1'b1;
        end
        if (pend_r && len_rdata != '0) begin
          code_we         = 1'b1;
          code_waddr      = pend_idx_r;
          code_wdata      = hcl_pkg::rev_code(nc_r[len_idx][CODEB-1:0], len_rdata[3:0]);
          nc_nxt[len_idx] = nc_r[len_idx] + 1'b1;
        end
        if (!issue && !pend_r) begin
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (out_free) begin
          out_valid_nxt                = 1'b1;
          out_word_nxt.result_kind     = hcl_pkg::KIND_STATUS;
          out_word_nxt.code_length     = '0;
          out_word_nxt.code_bits       = '0;
          out_word_nxt.length_overflow = over_r;
          state_nxt                    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase

    // start the length check sweep
    if (go_chk) begin
      sw_cnt_nxt = '0;
      over_nxt   = 1'b0;
      for (int t = 0; t < TD; t++) begin
        hist_nxt[t] = '0;
        nc_nxt[t]   = '0;
      end
      state_nxt = S_CHK;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      pend_r      <= 1'b0;
      built_r     <= 1'b0;
      out_valid_r <= 1'b0;
      sym_r       <= 9'd286;
      inc_r       <= 8'd20;
    end else begin
      state_r     <= state_nxt;
      pend_r      <= pend_nxt;
      built_r     <= built_nxt;
      out_valid_r <= out_valid_nxt;
      sym_r       <= sym_nxt;
      inc_r       <= inc_nxt;
    end
    sw_cnt_r   <= sw_cnt_nxt;
    pend_idx_r <= pend_idx_nxt;
    n_r        <= n_nxt;
    idx_r      <= idx_nxt;
    idx_ok_r   <= idx_ok_nxt;
    g1_r       <= g1_nxt;
    g2_r       <= g2_nxt;
    over_r     <= over_nxt;
    k_r        <= k_nxt;
    hist_r     <= hist_nxt;
    nc_r       <= nc_nxt;
    out_word_r <= out_word_nxt;
  end

endmodule

`default_nettype wire

// ----- rtl/hcl_checker.sv -----
// port-level checks for the huffman code length builder, bound to the top
// depends on hcl_pkg and assert_macros.svh
`default_nettype none
`include "assert_macros.svh"

module hcl_port_checks (
  input wire logic               clk,
  input wire logic               rst_n,
  input wire logic               in_valid,
  input wire logic               in_stall,
  input wire hcl_pkg::in_word_t  in_word,
  input wire logic               out_valid,
  input wire logic               out_stall,
  input wire hcl_pkg::out_word_t out_word
);

  // a waiting result word is held
  `HCL_ASSERT(a_out_hold, out_valid && out_stall |=> out_valid && $stable(out_word), "result word changed while stalled")

  // status words carry no length or code
  `HCL_ASSERT(a_status_zero, out_valid && out_word.result_kind == hcl_pkg::KIND_STATUS |-> out_word.code_length == 4'd0 && out_word.code_bits == '0, "status word with nonzero fields")

  // entry words never flag overflow
  `HCL_ASSERT(a_entry_flag, out_valid && out_word.result_kind == hcl_pkg::KIND_ENTRY |-> !out_word.length_overflow, "entry word with overflow flag")

  // a build or read blocks the input on the next cycle
  `HCL_ASSERT(a_busy, in_valid && !in_stall && (in_word.operation == hcl_pkg::OP_BUILD || in_word.operation == hcl_pkg::OP_READ) |=> in_stall, "input not stalled after build or read")

  // nothing is offered right after reset
  `HCL_ASSERT_RST(a_reset, !rst_n |=> !out_valid, "result valid after reset")

endmodule

bind huffman_code_length_builder hcl_port_checks u_hcl_port_checks (.*);

`default_nettype wire
